// File: hdl/assert_macros.svh
// Assertion helpers for the scanner control word builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: hdl/iscwb_pkg.sv
package iscwb_pkg;

  localparam int MAX_INPUTS = 32;
  localparam logic [23:0] RATE_CAP = 24'd10000000;
  localparam logic [9:0] DIV_MAX = 10'd1023;
  localparam logic [5:0] FAST_MAX = 6'd63;
  localparam logic [9:0] SLOW_MAX = 10'd1023;

  localparam logic [1:0] CFG_CLOCK_HZ = 2'd0;
  localparam logic [1:0] CFG_INPUT_WIDTH = 2'd1;

  localparam int MAIN_STEPS = 4;
  localparam int WID_STEPS = 7;

  // 10,000,000 / width, indexed by width - 1
  localparam logic [23:0] RATE_DIV_TBL [0:31] = '{
    24'd10000000, 24'd5000000, 24'd3333333, 24'd2500000,
    24'd2000000, 24'd1666666, 24'd1428571, 24'd1250000,
    24'd1111111, 24'd1000000, 24'd909090, 24'd833333,
    24'd769230, 24'd714285, 24'd666666, 24'd625000,
    24'd588235, 24'd555555, 24'd526315, 24'd500000,
    24'd476190, 24'd454545, 24'd434782, 24'd416666,
    24'd400000, 24'd384615, 24'd370370, 24'd357142,
    24'd344827, 24'd333333, 24'd322580, 24'd312500
  };

  typedef struct packed {
    logic [31:0] req;
    logic [5:0]  fast;
    logic [9:0]  slow;
    logic        fflag;
    logic        sflag;
    logic [31:0] filter;
    logic [24:0] mode;
    logic        too_high;
    logic        zero;
    logic [23:0] gr_hi;
    logic [25:0] d;
    logic [36:0] m;
    logic [25:0] rem;
    logic [11:0] dnd;
    logic [11:0] quo;
    logic [5:0]  wrem;
    logic [20:0] wdnd;
    logic [20:0] wquo;
  } item_t;

endpackage

// File: hdl/iscwb_if.sv
interface iscwb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] rate_request;
  logic [31:0] fast_count;
  logic [31:0] slow_count;
  logic [31:0] long_filter_mask;
  logic [3:0]  encoder_modes;
  modport source (output valid, rate_request, fast_count, slow_count,
                  long_filter_mask, encoder_modes, input ready);
  modport sink (input valid, rate_request, fast_count, slow_count,
                long_filter_mask, encoder_modes, output ready);
endinterface

interface iscwb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] control_word;
  logic [31:0] filter_word;
  logic [24:0] mode_word;
  logic [31:0] rate_granted;
  logic [5:0]  fast_granted;
  logic [9:0]  slow_granted;
  logic        rate_too_high;
  logic        rate_too_low;
  logic        fast_clamped;
  logic        slow_clamped;
  modport source (output valid, control_word, filter_word, mode_word, rate_granted,
                  fast_granted, slow_granted, rate_too_high, rate_too_low,
                  fast_clamped, slow_clamped, input ready);
  modport sink (input valid, control_word, filter_word, mode_word, rate_granted,
                fast_granted, slow_granted, rate_too_high, rate_too_low,
                fast_clamped, slow_clamped, output ready);
endinterface

// File: hdl/iscwb_div_stage.sv
// One pipeline stage of both restoring dividers.
module iscwb_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [5:0]         w,
  input  logic               up_valid,
  output logic               up_ready,
  input  iscwb_pkg::item_t   up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output iscwb_pkg::item_t   dn_data
);

  logic             v_r;
  iscwb_pkg::item_t d_r;
  iscwb_pkg::item_t d_nxt;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    logic [26:0] t;
    logic [5:0]  wt;
    d_nxt = up_data;
    for (int i = 0; i < iscwb_pkg::MAIN_STEPS; i++) begin
      t = {d_nxt.rem, d_nxt.dnd[11]};
      d_nxt.dnd = {d_nxt.dnd[10:0], 1'b0};
      if (t >= {1'b0, d_nxt.d}) begin
        d_nxt.rem = 26'(t - {1'b0, d_nxt.d});
        d_nxt.quo = {d_nxt.quo[10:0], 1'b1};
      end else begin
        d_nxt.rem = t[25:0];
        d_nxt.quo = {d_nxt.quo[10:0], 1'b0};
      end
    end
    for (int i = 0; i < iscwb_pkg::WID_STEPS; i++) begin
      wt = {d_nxt.wrem[4:0], d_nxt.wdnd[20]};
      d_nxt.wdnd = {d_nxt.wdnd[19:0], 1'b0};
      if (wt >= w) begin
        d_nxt.wrem = wt - w;
        d_nxt.wquo = {d_nxt.wquo[19:0], 1'b1};
      end else begin
        d_nxt.wrem = wt;
        d_nxt.wquo = {d_nxt.wquo[19:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      d_r <= d_nxt;
    end
  end

endmodule

// File: hdl/input_scanner_control_word_builder_top.sv
// Builds the debounce scanner control, filter and encoder mode words from
// one item of scan settings. Fully pipelined: one item enters per cycle
// unless out_ch.ready stalls it; stages are front, scaling multiply, three
// divider stages, output register. The rate divisor is a 12-bit restoring
// division of clock_hz by 4*total (four bits per stage); the too-slow granted
// rate divides clock_hz/4096 by the input width (seven bits per stage), both
// over the three divider stages. The user must write configuration through
// cfg_we/cfg_idx/cfg_data only while no item is in flight (not enforced).
`include "assert_macros.svh"

module input_scanner_control_word_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [30:0] cfg_data,
  iscwb_in_if.sink    in_ch,
  iscwb_out_if.source out_ch
);

  logic [30:0] clock_r;
  logic [5:0]  width_r;
  logic [5:0]  w;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= 31'd100000000;
      width_r <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_idx)
        iscwb_pkg::CFG_CLOCK_HZ:    clock_r <= cfg_data;
        iscwb_pkg::CFG_INPUT_WIDTH: width_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // effective width, 1..MAX_INPUTS
  always_comb begin
    if (width_r == 6'd0) begin
      w = 6'd1;
    end else if (width_r > 6'(iscwb_pkg::MAX_INPUTS)) begin
      w = 6'(iscwb_pkg::MAX_INPUTS);
    end else begin
      w = width_r;
    end
  end

  // stage 1: scaling, capping, clamps, packing of side words
  iscwb_pkg::item_t s1_nxt, s1_r, s2_nxt, s2_r, s3_d, s4_d, s5_d;
  logic s1_v_r, s2_v_r, s1_rdy, s2_rdy;
  logic s3_v, s4_v, s5_v, s3_rdy, s4_rdy, s5_rdy;
  logic out_v_r, out_rdy;

  always_comb begin
    logic [37:0] total;
    logic [23:0] tcap;
    s1_nxt = '0;
    total = 38'(w) * 38'(in_ch.rate_request);
    s1_nxt.req = in_ch.rate_request;
    s1_nxt.too_high = total > 38'(iscwb_pkg::RATE_CAP);
    tcap = s1_nxt.too_high ? iscwb_pkg::RATE_CAP : total[23:0];
    s1_nxt.zero = (tcap == 24'd0);
    s1_nxt.d = {tcap, 2'b00};
    s1_nxt.gr_hi = iscwb_pkg::RATE_DIV_TBL[5'(w - 6'd1)];
    if (in_ch.fast_count > 32'(iscwb_pkg::FAST_MAX)) begin
      s1_nxt.fast = iscwb_pkg::FAST_MAX;
      s1_nxt.fflag = 1'b1;
    end else if (in_ch.fast_count == 32'd0) begin
      s1_nxt.fast = 6'd1;
      s1_nxt.fflag = 1'b1;
    end else begin
      s1_nxt.fast = in_ch.fast_count[5:0];
    end
    if (in_ch.slow_count > 32'(iscwb_pkg::SLOW_MAX)) begin
      s1_nxt.slow = iscwb_pkg::SLOW_MAX;
      s1_nxt.sflag = 1'b1;
    end else if (in_ch.slow_count == 32'd0) begin
      s1_nxt.slow = 10'd1;
      s1_nxt.sflag = 1'b1;
    end else begin
      s1_nxt.slow = in_ch.slow_count[9:0];
    end
    for (int i = 0; i < 32; i++) begin
      s1_nxt.filter[i] = in_ch.long_filter_mask[i] && (6'(i) < w);
    end
    s1_nxt.mode = {in_ch.encoder_modes[3], 7'd0, in_ch.encoder_modes[2], 7'd0,
                   in_ch.encoder_modes[1], 7'd0, in_ch.encoder_modes[0]};
    // quotient is under 4096 whenever it matters, so the top bits start
    // out as the partial remainder
    s1_nxt.rem = {7'd0, clock_r[30:12]};
    s1_nxt.dnd = clock_r[11:0];
    s1_nxt.wdnd = {2'b00, clock_r[30:12]};
  end

  // stage 2: 1025*d, q reaches 1025 exactly when clock_hz >= this
  always_comb begin
    s2_nxt = s1_r;
    s2_nxt.m = (37'(s1_r.d) << 10) + 37'(s1_r.d);
  end

  assign s1_rdy = !s1_v_r || s2_rdy;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign in_ch.ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_ch.valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) s1_r <= s1_nxt;
    if (s2_rdy) s2_r <= s2_nxt;
  end

  iscwb_div_stage u_div0 (
    .clk(clk), .rst_n(rst_n), .w(w),
    .up_valid(s2_v_r), .up_ready(s3_rdy), .up_data(s2_r),
    .dn_valid(s3_v), .dn_ready(s4_rdy), .dn_data(s3_d)
  );
  iscwb_div_stage u_div1 (
    .clk(clk), .rst_n(rst_n), .w(w),
    .up_valid(s3_v), .up_ready(s4_rdy), .up_data(s3_d),
    .dn_valid(s4_v), .dn_ready(s5_rdy), .dn_data(s4_d)
  );
  iscwb_div_stage u_div2 (
    .clk(clk), .rst_n(rst_n), .w(w),
    .up_valid(s4_v), .up_ready(s5_rdy), .up_data(s4_d),
    .dn_valid(s5_v), .dn_ready(out_rdy), .dn_data(s5_d)
  );

  // output stage: divisor select, granted rate, final words
  logic        big, too_low;
  logic [9:0]  div;
  logic [31:0] granted;

  always_comb begin
    big = {6'd0, clock_r} >= s5_d.m;
    too_low = s5_d.zero || big;
    if (too_low) begin
      div = iscwb_pkg::DIV_MAX;
      granted = {11'd0, s5_d.wquo};
    end else begin
      div = (s5_d.quo != 12'd0) ? 10'(s5_d.quo - 12'd1) : 10'd0;
      granted = s5_d.too_high ? {8'd0, s5_d.gr_hi} : s5_d.req;
    end
  end

  assign out_rdy = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      out_ch.control_word  <= {s5_d.slow, s5_d.fast, div, 6'b100000};
      out_ch.filter_word   <= s5_d.filter;
      out_ch.mode_word     <= s5_d.mode;
      out_ch.rate_granted  <= granted;
      out_ch.fast_granted  <= s5_d.fast;
      out_ch.slow_granted  <= s5_d.slow;
      out_ch.rate_too_high <= s5_d.too_high;
      out_ch.rate_too_low  <= too_low;
      out_ch.fast_clamped  <= s5_d.fflag;
      out_ch.slow_clamped  <= s5_d.sflag;
    end
  end

  assign out_ch.valid = out_v_r;

  `ASSERT_CLK(a_invert_set, clk, rst_n, out_v_r |-> out_ch.control_word[5])
  `ASSERT_CLK(a_slow_div, clk, rst_n,
    (out_v_r && out_ch.rate_too_low) |-> (out_ch.control_word[15:6] == iscwb_pkg::DIV_MAX))
  `ASSERT_NEVER(a_fast_zero, clk, rst_n, out_v_r && (out_ch.fast_granted == 6'd0))
  `ASSERT_CLK(a_fast_packed, clk, rst_n,
    out_v_r |-> (out_ch.control_word[21:16] == out_ch.fast_granted))

endmodule
